[hdl/fra_pkg.sv]
// Package: sizes, codes and controller/datapath interface types for the range allocator.
`timescale 1ns / 1ps
`default_nettype none
package fra_pkg;

  localparam int MAX_RANGES = 64;
  localparam int NB         = 2 * MAX_RANGES;
  localparam int SD         = NB + 4;
  localparam int BAW        = $clog2(NB);
  localparam int SAW        = $clog2(SD);
  localparam int CW         = $clog2(SD + 1);
  localparam int PAGE_SHIFT = 12;
  localparam logic [63:0] ALL_ONES = {64{1'b1}};

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_RSV   = 2'd1;
  localparam logic [1:0] OP_ALLOC = 2'd2;
  localparam logic [1:0] OP_GIVE  = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_IGNORE = 2'd3;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LATCH,
    DP_RST_IDX,
    DP_NORM_USE,
    DP_NORM_END,
    DP_LD_A,
    DP_LD_B,
    DP_EMIT_A,
    DP_EMIT_B,
    DP_EMIT_S,
    DP_EMIT_E,
    DP_MERGE,
    DP_CHK_FIRST,
    DP_SET_LAST,
    DP_CHK_LAST,
    DP_ALLOC_DEC,
    DP_SET_BEST,
    DP_ALLOC_WR,
    DP_CP_START,
    DP_COPY,
    DP_SET_CNT,
    DP_GIVE_B,
    DP_GIVE_A,
    DP_SAVE_PB,
    DP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] st;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       toobig;
    logic       rd_done;
    logic       cp_done;
    logic       cnt_zero;
    logic       cnt_odd;
    logic       k_over;
    logic       e_le_s;
    logic       b_lt_s;
    logic       a_gt_e;
    logic       b_le_s;
    logic       a_ge_e;
    logic       a_lt_s;
    logic       b_gt_e;
    logic       placed;
    logic       found;
    logic       cov;
    logic       b_eq_lo;
    logic       a_eq_up;
    logic       up_gt_q;
    logic       lo_lt_pb;
    logic       r_ge2;
  } dp_sts_t;

endpackage
`default_nettype wire

[hdl/free_range_allocator.sv]
// Top level: sorted free range table with merge, reserve, best-fit allocate and give-back.
//
//   channel  dir  handshake           payload
//   in_      in   in_valid/in_stall   in_opcode, in_address, in_length
//   out_     out  out_valid/out_stall out_result_address, out_status
//
// One request at a time; an oversized allocate is the shortest request and a give-back
// that falls back to an add the longest, whose time grows with the number n of stored bounds,
// set by the table walk through the bound memory (registered read port),
// the one-write-a-cycle scratch list and the copy back into the bound table.
// Reset: synchronous active-low; the table is empty and needs no clearing pass.
// A finished result waits in the output register; out_stall only holds the next finish.
`timescale 1ns / 1ps
`default_nettype none
module free_range_allocator
  import fra_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [63:0] in_address,
  input  wire logic [63:0] in_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_result_address,
  output logic [1:0]       out_status
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  fra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fra_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_opcode          (in_opcode),
    .in_address         (in_address),
    .in_length          (in_length),
    .out_result_address (out_result_address),
    .out_status         (out_status)
  );

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("not busy after accepting a request");

  a_addr_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_address != 64'd0 |-> out_status == ST_DONE)
    else $error("nonzero address with failure status");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.op == DP_FINISH))
    else $error("result shown without finish");

  a_count_even: assert property (@(posedge clk) disable iff (!rst_n)
    !sts.cnt_odd)
    else $error("odd bound count");

endmodule
`default_nettype wire

[hdl/fra_datapath.sv]
// Datapath: bound table, scratch table, working registers and compares.
`timescale 1ns / 1ps
`default_nettype none
module fra_datapath
  import fra_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  output dp_sts_t          sts,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [63:0] in_address,
  input  wire logic [63:0] in_length,
  output logic [63:0]      out_result_address,
  output logic [1:0]       out_status
);

  logic [63:0] bnd_mem [NB];
  logic [63:0] scr_mem [SD];

  logic [CW-1:0] cnt_r, ri_r, wi_r, best_r;
  logic [63:0]   s_r, e_r, a_r, b_r, pb_r, bsz_r, res_r, bq_r, sq_r;
  logic [1:0]    op_r;
  logic          toobig_r, hv_r, placed_r, found_r, cov_r;
  logic [63:0]   out_res_r;
  logic [1:0]    out_st_r;

  logic [CW-1:0] ri_m1, ri_m2;
  logic [64:0]   sum_len, sum_pg;
  logic [63:0]   pg_bytes, size, emit_d;
  logic          bnd_we;
  logic [BAW-1:0] bnd_wa;
  logic [63:0]   bnd_wd;

  assign ri_m1    = ri_r - CW'(1);
  assign ri_m2    = ri_r - CW'(2);
  assign sum_len  = {1'b0, in_address} + {1'b0, in_length};
  assign pg_bytes = (|in_length[63:64-PAGE_SHIFT]) ? ALL_ONES : (in_length << PAGE_SHIFT);
  assign sum_pg   = {1'b0, in_address} + {1'b0, pg_bytes};
  assign size     = b_r - a_r;

  always_comb begin
    case (cmd.op)
      DP_EMIT_A: emit_d = a_r;
      DP_EMIT_B: emit_d = b_r;
      DP_EMIT_S: emit_d = s_r;
      default:   emit_d = e_r;
    endcase
  end

  always_comb begin
    bnd_we = 1'b0;
    bnd_wa = wi_r[BAW-1:0];
    bnd_wd = a_r;
    case (cmd.op)
      DP_NORM_USE: bnd_we = hv_r && (a_r != bq_r);
      DP_NORM_END: bnd_we = hv_r;
      DP_COPY: begin
        bnd_we = 1'b1;
        bnd_wa = ri_r[BAW-1:0];
        bnd_wd = sq_r;
      end
      DP_ALLOC_WR: begin
        bnd_we = 1'b1;
        bnd_wa = ri_r[BAW-1:0];
        bnd_wd = bq_r + e_r;
      end
      DP_GIVE_B: begin
        bnd_we = 1'b1;
        bnd_wa = ri_m1[BAW-1:0];
        bnd_wd = e_r;
      end
      DP_GIVE_A: begin
        bnd_we = 1'b1;
        bnd_wa = ri_m2[BAW-1:0];
        bnd_wd = s_r;
      end
      default: bnd_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (bnd_we) bnd_mem[bnd_wa] <= bnd_wd;
    bq_r <= bnd_mem[ri_r[BAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_EMIT_A || cmd.op == DP_EMIT_B || cmd.op == DP_EMIT_S ||
        cmd.op == DP_EMIT_E)
      scr_mem[wi_r[SAW-1:0]] <= emit_d;
    sq_r <= scr_mem[ri_r[SAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      case (cmd.op)
        DP_NORM_END: cnt_r <= wi_r + CW'(hv_r);
        DP_SET_CNT:  cnt_r <= wi_r;
        default:     cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LATCH: begin
        op_r     <= in_opcode;
        s_r      <= in_address;
        res_r    <= '0;
        toobig_r <= |in_length[63:64-PAGE_SHIFT];
        case (in_opcode)
          OP_ALLOC: e_r <= in_length << PAGE_SHIFT;
          OP_GIVE:  e_r <= sum_pg[64] ? ALL_ONES : sum_pg[63:0];
          default:  e_r <= sum_len[64] ? ALL_ONES : sum_len[63:0];
        endcase
      end
      DP_RST_IDX: begin
        ri_r     <= '0;
        wi_r     <= '0;
        hv_r     <= 1'b0;
        placed_r <= 1'b0;
        found_r  <= 1'b0;
      end
      DP_NORM_USE: begin
        ri_r <= ri_r + CW'(1);
        if (hv_r && a_r == bq_r) begin
          hv_r <= 1'b0;
        end else if (hv_r) begin
          wi_r <= wi_r + CW'(1);
          a_r  <= bq_r;
        end else begin
          a_r  <= bq_r;
          hv_r <= 1'b1;
        end
      end
      DP_LD_A: begin
        a_r  <= bq_r;
        ri_r <= ri_r + CW'(1);
      end
      DP_LD_B: begin
        b_r  <= bq_r;
        ri_r <= ri_r + CW'(1);
      end
      DP_EMIT_A, DP_EMIT_B, DP_EMIT_E: wi_r <= wi_r + CW'(1);
      DP_EMIT_S: begin
        wi_r     <= wi_r + CW'(1);
        placed_r <= 1'b1;
      end
      DP_MERGE: begin
        if (a_r < s_r) s_r <= a_r;
        if (b_r > e_r) e_r <= b_r;
      end
      DP_CHK_FIRST: cov_r <= (s_r <= bq_r);
      DP_SET_LAST:  ri_r <= cnt_r - CW'(1);
      DP_CHK_LAST:  cov_r <= cov_r && (e_r >= bq_r);
      DP_ALLOC_DEC: begin
        if (size >= e_r && (!found_r || size < bsz_r)) begin
          found_r <= 1'b1;
          best_r  <= ri_m2;
          bsz_r   <= size;
        end
      end
      DP_SET_BEST: ri_r <= best_r;
      DP_ALLOC_WR: res_r <= bq_r;
      DP_CP_START: ri_r <= '0;
      DP_COPY:     ri_r <= ri_r + CW'(1);
      DP_SAVE_PB:  pb_r <= b_r;
      DP_FINISH: begin
        out_res_r <= res_r;
        out_st_r  <= cmd.st;
      end
      default: ;
    endcase
  end

  assign out_result_address = out_res_r;
  assign out_status         = out_st_r;

  always_comb begin
    sts.opcode   = op_r;
    sts.toobig   = toobig_r;
    sts.rd_done  = (ri_r >= cnt_r);
    sts.cp_done  = (ri_r >= wi_r);
    sts.cnt_zero = (cnt_r == '0);
    sts.cnt_odd  = cnt_r[0];
    sts.k_over   = (wi_r > CW'(NB));
    sts.e_le_s   = (e_r <= s_r);
    sts.b_lt_s   = (b_r < s_r);
    sts.a_gt_e   = (a_r > e_r);
    sts.b_le_s   = (b_r <= s_r);
    sts.a_ge_e   = (a_r >= e_r);
    sts.a_lt_s   = (a_r < s_r);
    sts.b_gt_e   = (b_r > e_r);
    sts.placed   = placed_r;
    sts.found    = found_r;
    sts.cov      = cov_r;
    sts.b_eq_lo  = (b_r == s_r);
    sts.a_eq_up  = (a_r == e_r);
    sts.up_gt_q  = (e_r > bq_r);
    sts.lo_lt_pb = (s_r < pb_r);
    sts.r_ge2    = (ri_r >= CW'(4));
  end

endmodule
`default_nettype wire

[hdl/fra_ctrl.sv]
// Controller: sequences normalize, merge, split, best-fit and give-back passes.
`timescale 1ns / 1ps
`default_nettype none
module fra_ctrl
  import fra_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_IDLE, S_DISP, S_NW, S_NU, S_NE, S_PREP,
    S_RF_W, S_RF_U, S_RL_S, S_RL_W, S_RL_U, S_RDEC,
    S_PW_A, S_PU_A, S_PW_B, S_PU_B, S_DEC,
    S_E_S, S_E_E, S_E_A, S_E_B,
    S_R_A, S_R_S, S_R_E, S_R_B,
    S_TAIL, S_T_S, S_T_E,
    S_COMMIT, S_CW, S_CU, S_CE,
    S_A_SET, S_A_W, S_A_U,
    S_G_W, S_G_C, S_G_WB, S_G_WA, S_GO_ADD,
    S_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [1:0] st_r, st_nxt;
  logic       ov_r, ov_nxt;
  dp_op_t     op;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign cmd.op    = op;
  assign cmd.st    = st_r;

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    st_nxt    = st_r;
    ov_nxt    = ov_r && out_stall;
    op        = DP_NOP;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        op        = DP_LATCH;
        state_nxt = S_DISP;
      end
      S_DISP: begin
        op       = DP_RST_IDX;
        mode_nxt = sts.opcode;
        if (sts.opcode == OP_ALLOC && sts.toobig) begin
          st_nxt    = ST_NOFIT;
          state_nxt = S_FIN;
        end else if (sts.opcode == OP_ALLOC || sts.opcode == OP_GIVE) begin
          state_nxt = S_PW_A;
        end else begin
          state_nxt = S_NW;
        end
      end
      S_NW: state_nxt = sts.rd_done ? S_NE : S_NU;
      S_NU: begin
        op        = DP_NORM_USE;
        state_nxt = S_NW;
      end
      S_NE: begin
        op        = DP_NORM_END;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        op = DP_RST_IDX;
        if (mode_r == OP_RSV) begin
          if (sts.cnt_zero) begin
            st_nxt    = ST_DONE;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_RF_W;
          end
        end else if (sts.e_le_s) begin
          st_nxt    = ST_DONE;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_PW_A;
        end
      end
      S_RF_W: state_nxt = S_RF_U;
      S_RF_U: begin
        op        = DP_CHK_FIRST;
        state_nxt = S_RL_S;
      end
      S_RL_S: begin
        op        = DP_SET_LAST;
        state_nxt = S_RL_W;
      end
      S_RL_W: state_nxt = S_RL_U;
      S_RL_U: begin
        op        = DP_CHK_LAST;
        state_nxt = S_RDEC;
      end
      S_RDEC: begin
        op = DP_RST_IDX;
        if (sts.cov) begin
          st_nxt    = ST_IGNORE;
          state_nxt = S_FIN;
        end else if (sts.e_le_s) begin
          st_nxt    = ST_DONE;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_PW_A;
        end
      end
      S_PW_A: state_nxt = sts.rd_done ? S_TAIL : S_PU_A;
      S_PU_A: begin
        op        = DP_LD_A;
        state_nxt = S_PW_B;
      end
      S_PW_B: state_nxt = S_PU_B;
      S_PU_B: begin
        op        = DP_LD_B;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        case (mode_r)
          OP_ADD: begin
            if (sts.b_lt_s) state_nxt = S_E_A;
            else if (sts.a_gt_e) state_nxt = sts.placed ? S_E_A : S_E_S;
            else begin
              op        = DP_MERGE;
              state_nxt = S_PW_A;
            end
          end
          OP_RSV: begin
            if (sts.b_le_s || sts.a_ge_e) state_nxt = S_E_A;
            else if (sts.a_lt_s) state_nxt = S_R_A;
            else if (sts.b_gt_e) state_nxt = S_R_E;
            else state_nxt = S_PW_A;
          end
          OP_ALLOC: begin
            op        = DP_ALLOC_DEC;
            state_nxt = S_PW_A;
          end
          default: begin
            if (sts.b_eq_lo) begin
              state_nxt = !sts.rd_done ? S_G_W : S_G_WB;
            end else if (sts.a_eq_up) begin
              state_nxt = (sts.r_ge2 && sts.lo_lt_pb) ? S_GO_ADD : S_G_WA;
            end else begin
              op        = DP_SAVE_PB;
              state_nxt = S_PW_A;
            end
          end
        endcase
      end
      S_E_S: begin
        op        = DP_EMIT_S;
        state_nxt = S_E_E;
      end
      S_E_E: begin
        op        = DP_EMIT_E;
        state_nxt = S_E_A;
      end
      S_E_A: begin
        op        = DP_EMIT_A;
        state_nxt = S_E_B;
      end
      S_E_B: begin
        op        = DP_EMIT_B;
        state_nxt = S_PW_A;
      end
      S_R_A: begin
        op        = DP_EMIT_A;
        state_nxt = S_R_S;
      end
      S_R_S: begin
        op        = DP_EMIT_S;
        state_nxt = sts.b_gt_e ? S_R_E : S_PW_A;
      end
      S_R_E: begin
        op        = DP_EMIT_E;
        state_nxt = S_R_B;
      end
      S_R_B: begin
        op        = DP_EMIT_B;
        state_nxt = S_PW_A;
      end
      S_TAIL: begin
        case (mode_r)
          OP_ADD: state_nxt = sts.placed ? S_COMMIT : S_T_S;
          OP_RSV: state_nxt = S_COMMIT;
          OP_ALLOC: begin
            if (sts.found) begin
              state_nxt = S_A_SET;
            end else begin
              st_nxt    = ST_NOFIT;
              state_nxt = S_FIN;
            end
          end
          default: state_nxt = S_GO_ADD;
        endcase
      end
      S_T_S: begin
        op        = DP_EMIT_S;
        state_nxt = S_T_E;
      end
      S_T_E: begin
        op        = DP_EMIT_E;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.k_over) begin
          st_nxt    = ST_FULL;
          state_nxt = S_FIN;
        end else begin
          op        = DP_CP_START;
          state_nxt = S_CW;
        end
      end
      S_CW: state_nxt = sts.cp_done ? S_CE : S_CU;
      S_CU: begin
        op        = DP_COPY;
        state_nxt = S_CW;
      end
      S_CE: begin
        op        = DP_SET_CNT;
        st_nxt    = ST_DONE;
        state_nxt = S_FIN;
      end
      S_A_SET: begin
        op        = DP_SET_BEST;
        state_nxt = S_A_W;
      end
      S_A_W: state_nxt = S_A_U;
      S_A_U: begin
        op        = DP_ALLOC_WR;
        st_nxt    = ST_DONE;
        state_nxt = S_FIN;
      end
      S_G_W: state_nxt = S_G_C;
      S_G_C: state_nxt = sts.up_gt_q ? S_GO_ADD : S_G_WB;
      S_G_WB: begin
        op        = DP_GIVE_B;
        st_nxt    = ST_DONE;
        state_nxt = S_FIN;
      end
      S_G_WA: begin
        op        = DP_GIVE_A;
        st_nxt    = ST_DONE;
        state_nxt = S_FIN;
      end
      S_GO_ADD: begin
        op        = DP_RST_IDX;
        mode_nxt  = OP_ADD;
        state_nxt = S_NW;
      end
      S_FIN: if (!ov_r || !out_stall) begin
        op        = DP_FINISH;
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= OP_ADD;
      st_r    <= ST_DONE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      st_r    <= st_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule
`default_nettype wire

[verif/free_range_allocator_test.sv]
// Testbench for free_range_allocator: directed and random requests checked against a table predictor.
`timescale 1ns / 1ps
module free_range_allocator_test;
  import fra_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [63:0] PAGE = 64'd4096;

  typedef struct packed {
    logic [63:0] result_address;
    logic [1:0]  status;
  } outcome_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [63:0] in_address;
  logic [63:0] in_length;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_result_address;
  logic [1:0]  out_status;

  free_range_allocator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_address(in_address), .in_length(in_length),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_address(out_result_address), .out_status(out_status)
  );

  // predictor state
  logic [63:0] bounds [0:NB-1];
  int unsigned nbounds;
  logic [63:0] merged [0:SD-1];

  outcome_t pending_outcomes[$];
  int error_count;
  int idle_percent;
  int stall_percent;
  bit hold_stall;
  int quiet_cycles;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    return (a > ALL_ONES - b) ? ALL_ONES : a + b;
  endfunction

  function automatic void squeeze();
    int unsigned j;
    j = 0;
    for (int unsigned i = 0; i < nbounds; i++) begin
      if (i + 1 < nbounds && bounds[i] == bounds[i+1]) begin
        i++;
      end else begin
        bounds[j] = bounds[i];
        j++;
      end
    end
    nbounds = j;
  endfunction

  function automatic logic [1:0] adopt(int unsigned k);
    if (k > NB) return ST_FULL;
    for (int unsigned i = 0; i < k; i++) bounds[i] = merged[i];
    nbounds = k;
    return ST_DONE;
  endfunction

  function automatic logic [1:0] union_range(logic [63:0] s, logic [63:0] e);
    int unsigned k;
    bit placed;
    logic [63:0] a, b;
    k = 0;
    placed = 0;
    squeeze();
    if (e <= s) return ST_DONE;
    for (int unsigned r = 0; r + 1 < nbounds; r += 2) begin
      a = bounds[r];
      b = bounds[r+1];
      if (b < s) begin
        merged[k] = a; merged[k+1] = b; k += 2;
      end else if (a > e) begin
        if (!placed) begin
          merged[k] = s; merged[k+1] = e; k += 2; placed = 1;
        end
        merged[k] = a; merged[k+1] = b; k += 2;
      end else begin
        if (a < s) s = a;
        if (b > e) e = b;
      end
    end
    if (!placed) begin
      merged[k] = s; merged[k+1] = e; k += 2;
    end
    return adopt(k);
  endfunction

  function automatic logic [1:0] carve_range(logic [63:0] s, logic [63:0] e);
    int unsigned k;
    logic [63:0] a, b;
    k = 0;
    squeeze();
    if (nbounds == 0) return ST_DONE;
    if (s <= bounds[0] && e >= bounds[nbounds-1]) return ST_IGNORE;
    if (e <= s) return ST_DONE;
    for (int unsigned r = 0; r + 1 < nbounds; r += 2) begin
      a = bounds[r];
      b = bounds[r+1];
      if (b <= s || a >= e) begin
        merged[k] = a; merged[k+1] = b; k += 2;
      end else begin
        if (a < s) begin
          merged[k] = a; merged[k+1] = s; k += 2;
        end
        if (b > e) begin
          merged[k] = e; merged[k+1] = b; k += 2;
        end
      end
    end
    return adopt(k);
  endfunction

  function automatic outcome_t best_fit(logic [63:0] pages);
    outcome_t o;
    int unsigned best;
    bit found;
    logic [63:0] best_size, need, size;
    o = '0;
    found = 0;
    best = 0;
    best_size = 0;
    if (pages > (ALL_ONES >> PAGE_SHIFT)) begin
      o.status = ST_NOFIT;
      return o;
    end
    need = pages << PAGE_SHIFT;
    for (int unsigned r = 0; r + 1 < nbounds; r += 2) begin
      size = bounds[r+1] - bounds[r];
      if (size >= need && (!found || size < best_size)) begin
        found = 1; best = r; best_size = size;
      end
    end
    if (!found) begin
      o.status = ST_NOFIT;
      return o;
    end
    o.result_address = bounds[best];
    bounds[best] = bounds[best] + need;
    o.status = ST_DONE;
    return o;
  endfunction

  function automatic logic [1:0] return_pages(logic [63:0] lo, logic [63:0] pages);
    logic [63:0] up;
    up = sat_sum(lo, (pages > (ALL_ONES >> PAGE_SHIFT)) ? ALL_ONES : pages << PAGE_SHIFT);
    for (int unsigned r = 0; r + 1 < nbounds; r += 2) begin
      if (bounds[r+1] == lo) begin
        if (r + 2 < nbounds && up > bounds[r+2]) break;
        bounds[r+1] = up;
        return ST_DONE;
      end
      if (bounds[r] == up) begin
        if (r >= 2 && lo < bounds[r-1]) break;
        bounds[r] = lo;
        return ST_DONE;
      end
    end
    return union_range(lo, up);
  endfunction

  function automatic outcome_t predict(logic [1:0] op, logic [63:0] addr, logic [63:0] len);
    outcome_t o;
    o = '0;
    case (op)
      OP_ADD:   o.status = union_range(addr, sat_sum(addr, len));
      OP_RSV:   o.status = carve_range(addr, sat_sum(addr, len));
      OP_ALLOC: o = best_fit(len);
      default:  o.status = return_pages(addr, len);
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    error_count++;
  endtask

  task automatic send_request(logic [1:0] op, logic [63:0] addr, logic [63:0] len);
    while ($urandom_range(99) < idle_percent) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_address <= addr;
    in_length  <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_outcomes.push_back(predict(op, addr, len));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result", out_result_address, 64'd0);
      end else begin
        outcome_t want;
        want = pending_outcomes.pop_front();
        if (out_result_address !== want.result_address)
          report_mismatch("result_address", out_result_address, want.result_address);
        if (out_status !== want.status)
          report_mismatch("status", {62'd0, out_status}, {62'd0, want.status});
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= hold_stall || ($urandom_range(99) < stall_percent);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("free_range_allocator_test: done, errors");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(OP_ALLOC, 64'd0, 64'd0);
    send_request(OP_RSV, 64'd0, 64'd100);
    send_request(OP_GIVE, 64'h10000, 64'd2);
    send_request(OP_ADD, 64'h100000, 64'h100000);
    send_request(OP_ADD, 64'h300000, 64'h1000);
    send_request(OP_ADD, 64'h200000, 64'h0);
    send_request(OP_ADD, 64'h200000, 64'h100000);
    send_request(OP_ADD, 64'hFFFF_FFFF_FFFF_F000, ALL_ONES);
    send_request(OP_ALLOC, 64'd0, 64'd0);
    send_request(OP_ALLOC, ALL_ONES, 64'd1);
    send_request(OP_ALLOC, 64'd0, 64'h0010_0000_0000_0000);
    send_request(OP_ALLOC, 64'd0, ALL_ONES);
    send_request(OP_RSV, 64'h180000, 64'h1000);
    send_request(OP_RSV, 64'h180000, 64'd0);
    send_request(OP_RSV, 64'd0, ALL_ONES);
    send_request(OP_GIVE, 64'h180000, 64'd1);
    send_request(OP_GIVE, 64'h17F000, 64'd1);
    send_request(OP_GIVE, 64'h2FF000, 64'd5);
    send_request(OP_GIVE, 64'h50000000, ALL_ONES);
    send_request(OP_ALLOC, 64'd0, 64'd3);
    drain();
  endtask

  task automatic test_table_full();
    for (int i = 0; i < 70; i++)
      send_request(OP_ADD, 64'h4000_0000 + 64'(i) * 64'h2000, 64'h1000);
    send_request(OP_RSV, 64'd0, ALL_ONES);
    drain();
  endtask

  task automatic random_request();
    logic [1:0] op;
    logic [63:0] addr, len;
    int pick;
    op = 2'($urandom_range(3));
    pick = $urandom_range(9);
    if (pick == 0) begin
      addr = {$urandom, $urandom};
      len  = {$urandom, $urandom};
    end else begin
      addr = 64'($urandom_range(255)) * PAGE;
      len  = (op == OP_ALLOC || op == OP_GIVE) ? 64'($urandom_range(8))
                                             : 64'($urandom_range(16)) * PAGE;
      if (pick == 1) len = len + 64'($urandom_range(4095));
    end
    send_request(op, addr, len);
  endtask

  task automatic test_random(int count, int idle, int stall);
    idle_percent  = idle;
    stall_percent = stall;
    for (int i = 0; i < count; i++) random_request();
    drain();
  endtask

  task automatic test_backpressure();
    idle_percent  = 0;
    stall_percent = 0;
    fork
      begin
        hold_stall = 1'b1;
        repeat (3000) @(negedge clk);
        hold_stall = 1'b0;
      end
      for (int i = 0; i < 10; i++) random_request();
    join
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_ADD;
    in_address = '0;
    in_length = '0;
    out_stall = 1'b0;
    hold_stall = 1'b0;
    idle_percent = 0;
    stall_percent = 0;
    error_count = 0;
    quiet_cycles = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_table_full();
    send_request(OP_RSV, 64'h4000_0000, 64'h100000);
    drain();
    test_random(170, 0, 0);
    test_random(170, 54, 0);
    test_random(170, 0, 54);
    test_random(170, 31, 31);
    test_backpressure();
    repeat (200) @(negedge clk);
    if (error_count == 0) begin
      $display("free_range_allocator_test: done, clean");
    end else begin
      $display("free_range_allocator_test: done, errors");
    end
    $finish;
  end

endmodule
